[hw/rtl/mask_grid_coarsen_3d_unit_assert.svh]
// Assertion macros for the mask grid coarsening block and its port checker.
// Needs nothing else; include by bare file name from the asserting file.
`ifndef MASK_GRID_COARSEN_3D_UNIT_ASSERT_SVH
`define MASK_GRID_COARSEN_3D_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define MGC3_ASSERT_SAME(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define MGC3_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mgc3_pkg.sv]
// Shared types and constants of the mask grid coarsening block.
// No dependencies; imported by the output queue, the top level and the checker.
`default_nettype none

package mgc3_pkg;

	// Register file geometry
	localparam int CFG_IDX_W    = 3;
	localparam int FINE_REG_W   = 10;
	localparam int COARSE_REG_W = 9;
	localparam int CELL_W       = 8;

	localparam logic [FINE_REG_W-1:0]   FINE_RST   = 10'd512;
	localparam logic [COARSE_REG_W-1:0] COARSE_RST = 9'd257;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FINE_X   = 3'd0,
		CFG_FINE_Y   = 3'd1,
		CFG_FINE_Z   = 3'd2,
		CFG_COARSE_X = 3'd3,
		CFG_COARSE_Y = 3'd4,
		CFG_COARSE_Z = 3'd5
	} cfg_idx_t;

	// Output queue geometry
	localparam int OUT_Q_DEPTH = 3;
	localparam int OUT_PTR_W   = $clog2(OUT_Q_DEPTH);
	localparam int OUT_CNT_W   = $clog2(OUT_Q_DEPTH + 1);

	// One emitted coarse cell
	typedef struct packed {
		logic [CELL_W-1:0] x;
		logic [CELL_W-1:0] y;
		logic [CELL_W-1:0] z;
		logic              value;
	} cell_t;

endpackage

`default_nettype wire

[hw/rtl/mgc3_out_fifo.sv]
// Three-entry result queue that decouples the plane pipeline from the consumer.
// Depends on mgc3_pkg for the cell type and queue geometry.
`default_nettype none

module mgc3_out_fifo (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire mgc3_pkg::cell_t               push_cell,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output mgc3_pkg::cell_t                    out_cell,
	output logic [mgc3_pkg::OUT_CNT_W-1:0]     count
);
	import mgc3_pkg::*;

	cell_t                slot_q [OUT_Q_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_cell  = slot_q[rd_ptr_q];
	assign count     = count_q;

	function automatic logic [OUT_PTR_W-1:0] ptr_next(input logic [OUT_PTR_W-1:0] p);
		return (p == OUT_PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
	endfunction

	// Store a beat at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cell;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OUT_CNT_W'(1);
				2'b01:   count_q <= count_q - OUT_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/mask_grid_coarsen_3d_unit.sv]
// Coarse-grid restriction of a streamed 3D binary mask, top level.
// Depends on mgc3_pkg and instantiates mgc3_out_fifo.
//
// Usage: fine voxels enter on in_valid/in_ready/voxel in raster order, x
// fastest, then y, then z; after the last voxel of a volume the next volume
// starts. Each interior coarse cell is the AND of its 2x2x2 fine block and
// leaves on out_valid/out_ready with cell_x/cell_y/cell_z/cell_value on the
// beat of its last contributing voxel; border cells are never sent.
// Sizes are written on cfg_valid/cfg_ready/cfg_index/cfg_data (always ready)
// while the block is idle (the user's rule; the block does not enforce it);
// indexes beyond the list are ignored. Throughput: one voxel per cycle while
// in_ready is high. A taken voxel's plane buffer read is registered with it,
// then the AND is written back and the result queued. Back-to-back
// hits on the same buffer entry are served by forwarding the pending write.
// Stall: a three-entry result queue absorbs results; in_ready drops only when
// the queue plus the result in flight would fill it.
// Reset: sizes return to 512 fine / 257 coarse, the raster position to zero
// and the queue empties. The plane buffer is not cleared; every entry is
// written by the base voxel of its cell before it is read.
`default_nettype none

module mask_grid_coarsen_3d_unit #(
	parameter int MAX_FINE   = 512,
	parameter int MAX_COARSE = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mgc3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mgc3_pkg::FINE_REG_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               voxel,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mgc3_pkg::CELL_W-1:0]             cell_x,
	output logic [mgc3_pkg::CELL_W-1:0]             cell_y,
	output logic [mgc3_pkg::CELL_W-1:0]             cell_z,
	output logic                                    cell_value
);
	import mgc3_pkg::*;

	localparam int PW    = $clog2(MAX_FINE);
	localparam int IW    = $clog2(MAX_FINE / 2 + 1);
	localparam int CW    = $clog2(MAX_COARSE);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int MW_A  = $clog2(MAX_FINE + 2);
	localparam int MW_B  = $clog2(MAX_COARSE + 1);
	localparam int MW    = (MW_A > MW_B) ? MW_A : MW_B;
	localparam int XW    = ((MW > FINE_REG_W) ? MW : FINE_REG_W) + 1;

	typedef struct packed {
		logic          hit;
		logic          base;
		logic          last;
		logic [IW-1:0] idx;
	} axis_t;

	// Clamp a fine size register to 1..MAX_FINE
	function automatic logic [XW-1:0] eff_fine(input logic [FINE_REG_W-1:0] n);
		logic [XW-1:0] w;
		w = XW'(n);
		if (w == '0) return XW'(1);
		if (w > XW'(MAX_FINE)) return XW'(MAX_FINE);
		return w;
	endfunction

	// Map one fine coordinate onto its coarse cell along one axis
	function automatic axis_t axis_map(input logic [PW-1:0] c, input logic [XW-1:0] nf,
			input logic [COARSE_REG_W-1:0] nc, input logic lim);
		axis_t         r;
		logic [XW-1:0] ce;
		logic [XW-1:0] iw;
		ce     = XW'(c);
		r.hit  = 1'b1;
		r.base = c[0];
		r.last = 1'b1;
		if (c[0]) begin
			iw     = (ce + XW'(1)) >> 1;
			r.last = !(ce + XW'(2) < nf);
		end else begin
			iw = ce >> 1;
			if (!(ce + XW'(1) < nf)) r.hit = 1'b0;
		end
		if (c == '0) r.hit = 1'b0;
		if (iw + XW'(2) > XW'(nc)) r.hit = 1'b0;
		if (lim && (iw >= XW'(MAX_COARSE))) r.hit = 1'b0;
		r.idx = IW'(iw);
		return r;
	endfunction

	// Configuration registers
	logic [FINE_REG_W-1:0]   fine_x_q, fine_y_q, fine_z_q;
	logic [COARSE_REG_W-1:0] coarse_x_q, coarse_y_q, coarse_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_x_q   <= FINE_RST;
			fine_y_q   <= FINE_RST;
			fine_z_q   <= FINE_RST;
			coarse_x_q <= COARSE_RST;
			coarse_y_q <= COARSE_RST;
			coarse_z_q <= COARSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FINE_X:   fine_x_q   <= cfg_data;
				CFG_FINE_Y:   fine_y_q   <= cfg_data;
				CFG_FINE_Z:   fine_z_q   <= cfg_data;
				CFG_COARSE_X: coarse_x_q <= COARSE_REG_W'(cfg_data);
				CFG_COARSE_Y: coarse_y_q <= COARSE_REG_W'(cfg_data);
				CFG_COARSE_Z: coarse_z_q <= COARSE_REG_W'(cfg_data);
				default: ;
			endcase
		end
	end

	logic [XW-1:0] nx, ny, nz;
	assign nx = eff_fine(fine_x_q);
	assign ny = eff_fine(fine_y_q);
	assign nz = eff_fine(fine_z_q);

	// Raster position of the next voxel
	logic [PW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [XW-1:0] px_nxt, py_nxt, pz_nxt, px_inc;
	logic          in_fire;

	assign in_fire = in_valid & in_ready;
	assign px_inc  = XW'(pos_x_q) + XW'(1);

	always_comb begin
		px_nxt = px_inc;
		py_nxt = XW'(pos_y_q);
		pz_nxt = XW'(pos_z_q);
		if (px_inc >= nx) begin
			px_nxt = '0;
			py_nxt = py_nxt + XW'(1);
			if (py_nxt >= ny) begin
				py_nxt = '0;
				pz_nxt = pz_nxt + XW'(1);
				if (pz_nxt >= nz) pz_nxt = '0;
			end
		end
		if (py_nxt >= ny) py_nxt = '0;
		if (pz_nxt >= nz) pz_nxt = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (in_fire) begin
			pos_x_q <= PW'(px_nxt);
			pos_y_q <= PW'(py_nxt);
			pos_z_q <= PW'(pz_nxt);
		end
	end

	// Stage 0: map the position onto a coarse cell and its buffer entry
	axis_t         map_x, map_y, map_z;
	logic          hit0, base0, last0;
	logic [AW-1:0] addr0;

	assign map_x = axis_map(pos_x_q, nx, coarse_x_q, 1'b1);
	assign map_y = axis_map(pos_y_q, ny, coarse_y_q, 1'b1);
	assign map_z = axis_map(pos_z_q, nz, coarse_z_q, 1'b0);
	assign hit0  = map_x.hit & map_y.hit & map_z.hit;
	assign base0 = map_x.base & map_y.base & map_z.base;
	assign last0 = map_x.last & map_y.last & map_z.last;
	assign addr0 = {CW'(map_y.idx), CW'(map_x.idx)};

	// Stage 1 registers
	logic          valid_s1, hit_s1, base_s1, last_s1, voxel_s1;
	logic          fwd_s1, fwd_val_s1, rd_s1;
	logic [AW-1:0] addr_s1;
	logic [IW-1:0] ix_s1, iy_s1, iz_s1;
	logic          acc, wr_en, push;

	// Partial AND for the entry, with the previous beat's write forwarded
	assign acc   = voxel_s1 & (base_s1 | (fwd_s1 ? fwd_val_s1 : rd_s1));
	assign wr_en = valid_s1 & hit_s1;
	assign push  = wr_en & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hit_s1     <= hit0;
			base_s1    <= base0;
			last_s1    <= last0;
			voxel_s1   <= voxel;
			addr_s1    <= addr0;
			ix_s1      <= map_x.idx;
			iy_s1      <= map_y.idx;
			iz_s1      <= map_z.idx;
			fwd_s1     <= wr_en && (addr_s1 == addr0);
			fwd_val_s1 <= acc;
		end
	end

	// Plane buffer: one read and one write-back per cycle
	logic plane_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= plane_mem[addr0];
		end
		if (wr_en) begin
			plane_mem[addr_s1] <= acc;
		end
	end

	// Result queue and input throttle
	cell_t                push_cell, out_cell;
	logic [OUT_CNT_W-1:0] q_count;
	logic [OUT_CNT_W:0]   q_load;

	assign push_cell.x     = CELL_W'(ix_s1);
	assign push_cell.y     = CELL_W'(iy_s1);
	assign push_cell.z     = CELL_W'(iz_s1);
	assign push_cell.value = acc;

	assign q_load   = {1'b0, q_count} + (OUT_CNT_W + 1)'(push);
	assign in_ready = (q_load <= (OUT_CNT_W + 1)'(OUT_Q_DEPTH - 1));

	mgc3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cell (push_cell),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_cell  (out_cell),
		.count     (q_count)
	);

	assign cell_x     = out_cell.x;
	assign cell_y     = out_cell.y;
	assign cell_z     = out_cell.z;
	assign cell_value = out_cell.value;

endmodule

`default_nettype wire

[hw/rtl/mgc3_checker.sv]
// Port-level checker for mask_grid_coarsen_3d_unit, bound to the top level.
// Depends on mgc3_pkg and the assertion macro header.
`default_nettype none

`include "mask_grid_coarsen_3d_unit_assert.svh"

module mgc3_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic [mgc3_pkg::CELL_W-1:0]        cell_x,
	input  wire logic [mgc3_pkg::CELL_W-1:0]        cell_y,
	input  wire logic [mgc3_pkg::CELL_W-1:0]        cell_z,
	input  wire logic                               cell_value
);
	import mgc3_pkg::*;

	// Hold a stalled result beat
	`MGC3_ASSERT_NEXT(out_hold_a, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cell_x) && $stable(cell_y) && $stable(cell_z) && $stable(cell_value), "stalled result beat changed")

	// Emit interior cells only along x and y; the z index wraps at eight bits
	`MGC3_ASSERT_SAME(interior_a, clk, arst_n, out_valid, cell_x != 8'd0 && cell_y != 8'd0, "border cell emitted")

	// A fresh result follows an earlier voxel beat
	`MGC3_ASSERT_SAME(latency_a, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a voxel beat")

	// Throttle input only while results are waiting
	`MGC3_ASSERT_SAME(throttle_a, clk, arst_n, !in_ready, out_valid, "input stalled with no pending result")

endmodule

bind mask_grid_coarsen_3d_unit mgc3_checker u_mgc3_checker (.*);

`default_nettype wire
